>>> rtl/core/buzzer_melody_sequencer_defines.svh
`ifndef BUZZER_MELODY_SEQUENCER_DEFINES_SVH
`define BUZZER_MELODY_SEQUENCER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define BMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define BMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/bms_pkg.sv
`timescale 1ns / 1ps

package bms_pkg;

  localparam int NUM_TUNES      = 8;
  localparam int NOTES_PER_TUNE = 32;

  localparam int PERIOD_W     = 16;
  localparam int DUTY_W       = 7;
  localparam int DUTY_RESET   = 50;
  localparam int PERCENT      = 100;

  // floor(x / 100) == (x * RECIP) >> CMP_SHIFT for every x below 2^23
  localparam int CMP_SHIFT    = 30;
  localparam int RECIP        = ((2 ** CMP_SHIFT) + PERCENT - 1) / PERCENT;
  localparam int DUTY_SCALE_W = 31;

  typedef logic [DUTY_SCALE_W-1:0] duty_scale_t;

  localparam duty_scale_t DUTY_SCALE_RESET = duty_scale_t'(DUTY_RESET * RECIP);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef struct packed {
    logic                is_end;
    logic [PERIOD_W-1:0] duration;
    logic [PERIOD_W-1:0] period;
  } note_t;

  typedef struct packed {
    logic [1:0]          pad;
    logic [2:0]          active_priority;
    logic                playing;
    logic                power_on;
    logic                pwm_active;
    logic [PERIOD_W-1:0] pwm_compare;
    logic [PERIOD_W-1:0] pwm_period;
  } result_t;

endpackage

>>> rtl/core/buzzer_melody_sequencer.sv
`timescale 1ns / 1ps
`include "buzzer_melody_sequencer_defines.svh"

// channel   direction  handshake                         payload
// s_axis    in         s_axis_tvalid_i / s_axis_tready_o  tdata, tuser (op), tlast (end flag)
// m_axis    out        m_axis_tvalid_o / m_axis_tready_i  tdata (timer settings and status)
// cfg       in         cfg_we_i                           cfg_wdata_i (duty percent)
//
// the note memory is read when a request is accepted; the execute step that
// follows updates the player state and loads the output register
// the note memory read is registered
// s_axis_tready_o stays low while the previous request waits in execute
// a full, unread output register holds execution, and with it further requests
// reset clears the player state, duty to fifty percent; note memory is not cleared

module buzzer_melody_sequencer #(
  parameter int NumTunes     = bms_pkg::NUM_TUNES,
  parameter int NotesPerTune = bms_pkg::NOTES_PER_TUNE
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tune_id[2:0], note_slot[7:3], note_period[23:8], note_duration[39:24]
  input  logic [39:0] s_axis_tdata_i,
  // op[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // pwm_period[15:0], pwm_compare[31:16], pwm_active[32], power_on[33],
  // playing[34], active_priority[37:35], zero[39:38]
  output logic [39:0] m_axis_tdata_o
);

  localparam int Depth  = NumTunes * NotesPerTune;
  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int PosW   = $clog2(NotesPerTune);
  localparam int PerW   = bms_pkg::PERIOD_W;
  localparam int ProdW  = PerW + bms_pkg::DUTY_SCALE_W;
  localparam int ShiftW = bms_pkg::CMP_SHIFT;

  // input unpacking
  bms_pkg::op_e      in_op;
  logic [2:0]        in_tune;
  logic [4:0]        in_slot;
  bms_pkg::note_t    in_note;
  logic              accept;
  logic              in_tune_ok;
  logic              in_slot_ok;

  assign in_op            = bms_pkg::op_e'(s_axis_tuser_i);
  assign in_tune          = s_axis_tdata_i[2:0];
  assign in_slot          = s_axis_tdata_i[7:3];
  assign in_note.period   = s_axis_tdata_i[23:8];
  assign in_note.duration = s_axis_tdata_i[39:24];
  assign in_note.is_end   = s_axis_tlast_i;
  assign accept           = s_axis_tvalid_i && s_axis_tready_o;
  assign in_tune_ok       = int'(in_tune) < NumTunes;
  assign in_slot_ok       = int'(in_slot) < NotesPerTune;

  // player state
  logic                 ex_valid_q;
  bms_pkg::op_e         ex_op_q;
  logic [2:0]           ex_tune_q;
  logic                 out_valid_q;
  bms_pkg::result_t     out_data_q;
  bms_pkg::duty_scale_t duty_scale_q;
  bms_pkg::note_t       rd_note_q;
  logic [PerW-1:0]      elapsed_q, elapsed_d;
  logic [PosW-1:0]      pos_q, pos_d;
  logic [2:0]           tune_q, tune_d;
  logic [PerW-1:0]      dur_q, dur_d;
  logic                 busy_q, busy_d;
  logic [2:0]           prio_q, prio_d;
  logic [PerW-1:0]      period_q, period_d;
  logic [PerW-1:0]      cmp_q, cmp_d;
  logic                 active_q, active_d;
  logic                 power_q, power_d;

  // note memory
  bms_pkg::note_t mem_q [Depth];
  logic             mem_we;
  logic             rd_en;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;
  logic [PosW:0]    pos_inc;

  assign pos_inc = (PosW+1)'(pos_q) + (PosW+1)'(1);
  assign mem_we  = accept && (in_op == bms_pkg::OP_WRITE) && in_tune_ok && in_slot_ok;
  assign wr_addr = AddrW'(int'(in_tune) * NotesPerTune + int'(in_slot));
  assign rd_en   = accept && (((in_op == bms_pkg::OP_START) && in_tune_ok) ||
                   ((in_op == bms_pkg::OP_TICK) && busy_q &&
                    (int'(pos_inc) < NotesPerTune)));
  assign rd_addr = (in_op == bms_pkg::OP_START) ?
                   AddrW'(int'(in_tune) * NotesPerTune) :
                   AddrW'(int'(tune_q) * NotesPerTune + int'(pos_inc));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= in_note;
    end
    if (rd_en) begin
      rd_note_q <= mem_q[rd_addr];
    end
  end

  // execute
  logic             fire;
  logic [ProdW-1:0] prod;
  logic [PerW:0]    cmp_wide;
  logic [PerW-1:0]  cmp_sat;
  logic [PerW-1:0]  elapsed_inc;
  logic             ex_tune_ok;

  assign fire        = ex_valid_q && (!out_valid_q || m_axis_tready_i);
  assign prod        = ProdW'(rd_note_q.period) * ProdW'(duty_scale_q);
  assign cmp_wide    = prod[ShiftW +: (PerW+1)];
  assign cmp_sat     = cmp_wide[PerW] ? '1 : cmp_wide[PerW-1:0];
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + PerW'(1);
  assign ex_tune_ok  = int'(ex_tune_q) < NumTunes;

  always_comb begin
    elapsed_d = elapsed_q;
    pos_d     = pos_q;
    tune_d    = tune_q;
    dur_d     = dur_q;
    busy_d    = busy_q;
    prio_d    = prio_q;
    period_d  = period_q;
    cmp_d     = cmp_q;
    active_d  = active_q;
    power_d   = power_q;
    if (fire) begin
      case (ex_op_q)
        bms_pkg::OP_START: begin
          if (ex_tune_ok && (ex_tune_q >= prio_q)) begin
            pos_d     = '0;
            elapsed_d = '0;
            tune_d    = ex_tune_q;
            prio_d    = ex_tune_q;
            busy_d    = 1'b1;
            dur_d     = rd_note_q.duration;
            if (rd_note_q.is_end) begin
              busy_d   = 1'b0;
              prio_d   = '0;
              active_d = 1'b0;
              power_d  = 1'b0;
            end else if (rd_note_q.period != '0) begin
              period_d = rd_note_q.period;
              cmp_d    = cmp_sat;
              active_d = 1'b1;
              power_d  = 1'b1;
            end else begin
              active_d = 1'b0;
              power_d  = 1'b0;
            end
          end
        end
        bms_pkg::OP_TICK: begin
          if (busy_q) begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc >= dur_q) begin
              elapsed_d = '0;
              pos_d     = pos_inc[PosW-1:0];
              if ((int'(pos_inc) >= NotesPerTune) || rd_note_q.is_end) begin
                // past the last slot or end-flagged note
                busy_d   = 1'b0;
                prio_d   = '0;
                active_d = 1'b0;
                power_d  = 1'b0;
              end else if (rd_note_q.period == '0) begin
                dur_d   = rd_note_q.duration;
                power_d = 1'b0;
              end else begin
                dur_d    = rd_note_q.duration;
                period_d = rd_note_q.period;
                cmp_d    = cmp_sat;
                active_d = 1'b1;
                power_d  = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      duty_scale_q <= bms_pkg::DUTY_SCALE_RESET;
      elapsed_q    <= '0;
      pos_q        <= '0;
      tune_q       <= '0;
      dur_q        <= '0;
      busy_q       <= 1'b0;
      prio_q       <= '0;
      period_q     <= '0;
      cmp_q        <= '0;
      active_q     <= 1'b0;
      power_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        duty_scale_q <= bms_pkg::duty_scale_t'(int'(cfg_wdata_i) * bms_pkg::RECIP);
      end
      if (accept) begin
        ex_valid_q <= 1'b1;
      end else if (fire) begin
        ex_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      elapsed_q <= elapsed_d;
      pos_q     <= pos_d;
      tune_q    <= tune_d;
      dur_q     <= dur_d;
      busy_q    <= busy_d;
      prio_q    <= prio_d;
      period_q  <= period_d;
      cmp_q     <= cmp_d;
      active_q  <= active_d;
      power_q   <= power_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ex_op_q   <= in_op;
      ex_tune_q <= in_tune;
    end
    if (fire) begin
      out_data_q.pad             <= '0;
      out_data_q.active_priority <= prio_d;
      out_data_q.playing         <= busy_d;
      out_data_q.power_on        <= power_d;
      out_data_q.pwm_active      <= active_d;
      out_data_q.pwm_compare     <= cmp_d;
      out_data_q.pwm_period      <= period_d;
    end
  end

  assign s_axis_tready_o = !ex_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `BMS_ASSERT_NOW(a_idle_prio_zero, !busy_q, prio_q == '0, "priority held while idle")
  `BMS_ASSERT_NOW(a_power_needs_pwm, power_q, active_q, "power on with output forced low")
  `BMS_ASSERT_NOW(a_pos_in_range, busy_q, int'(pos_q) < NotesPerTune, "note position out of range")
  `BMS_ASSERT_NEXT(a_accept_to_ex, accept, ex_valid_q, "accepted request not in execute")
  `BMS_ASSERT_NEXT(a_stall_holds_ex, ex_valid_q && out_valid_q && !m_axis_tready_i, ex_valid_q,
                   "stalled request lost")

endmodule

>>> verif/buzzer_melody_sequencer_tb.sv
`timescale 1ns / 1ps

module buzzer_melody_sequencer_tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SLOTS      = bms_pkg::NUM_TUNES * bms_pkg::NOTES_PER_TUNE;
  localparam int CHUNK      = 260;
  localparam int HOLD_LEN   = 300;
  localparam int IDLE_LIMIT = 3000;

  typedef struct {
    logic [1:0]  op;
    logic [2:0]  tune;
    logic [4:0]  slot;
    logic [15:0] period;
    logic [15:0] duration;
    logic        is_end;
  } req_t;

  class melody_tracker;
    bms_pkg::note_t   notes [SLOTS];
    bit               written [SLOTS];
    logic [15:0]      elapsed;
    int               pos;
    int               tune_now;
    int               prio;
    int unsigned      duty;
    bms_pkg::note_t   cur;
    bit               busy;
    bit               pwm_on;
    bit               power;
    logic [15:0]      per;
    logic [15:0]      cmp;
    bms_pkg::result_t timer_q[$];
    int               errors;

    function new();
      foreach (written[i]) written[i] = 1'b0;
      elapsed  = '0;
      pos      = 0;
      tune_now = 0;
      prio     = 0;
      duty     = bms_pkg::DUTY_RESET;
      cur      = '0;
      busy     = 1'b0;
      pwm_on   = 1'b0;
      power    = 1'b0;
      per      = '0;
      cmp      = '0;
      errors   = 0;
    endfunction

    function void load_timer(logic [15:0] p);
      int unsigned c;
      if (p != 0) begin
        c = 32'(p);
        c = (c * duty) / bms_pkg::PERCENT;
        if (c > 32'hFFFF) c = 32'hFFFF;
        per    = p;
        cmp    = c[15:0];
        pwm_on = 1'b1;
        power  = 1'b1;
      end else begin
        pwm_on = 1'b0;
        power  = 1'b0;
      end
    endfunction

    function void stop_tune();
      busy = 1'b0;
      prio = 0;
      load_timer('0);
    endfunction

    function void apply_request(req_t r);
      bms_pkg::result_t want;
      int               idx;
      idx = int'(r.tune) * bms_pkg::NOTES_PER_TUNE + int'(r.slot);
      if (r.op == bms_pkg::OP_WRITE) begin
        notes[idx]   = '{r.is_end, r.duration, r.period};
        written[idx] = 1'b1;
      end else if (r.op == bms_pkg::OP_START) begin
        if (int'(r.tune) >= prio) begin
          pos      = 0;
          elapsed  = '0;
          tune_now = int'(r.tune);
          prio     = int'(r.tune);
          busy     = 1'b1;
          cur      = notes[int'(r.tune) * bms_pkg::NOTES_PER_TUNE];
          if (cur.is_end) stop_tune();
          else load_timer(cur.period);
        end
      end else if (r.op == bms_pkg::OP_TICK && busy) begin
        if (elapsed != 16'hFFFF) elapsed++;
        if (elapsed >= cur.duration) begin
          elapsed = '0;
          pos++;
          if (pos >= bms_pkg::NOTES_PER_TUNE) begin
            stop_tune();
          end else begin
            cur = notes[tune_now * bms_pkg::NOTES_PER_TUNE + pos];
            if (cur.is_end) stop_tune();
            else if (cur.period == 0) power = 1'b0;
            else load_timer(cur.period);
          end
        end
      end
      want = '0;
      want.pwm_period      = per;
      want.pwm_compare     = cmp;
      want.pwm_active      = pwm_on;
      want.power_on        = power;
      want.playing         = busy;
      want.active_priority = prio[2:0];
      timer_q.push_back(want);
    endfunction

    function void compare_timer(bms_pkg::result_t got);
      bms_pkg::result_t want;
      if (timer_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %h", got);
        return;
      end
      want = timer_q.pop_front();
      if (got.pwm_period !== want.pwm_period || got.pwm_compare !== want.pwm_compare ||
          got.pwm_active !== want.pwm_active || got.power_on !== want.power_on ||
          got.playing !== want.playing ||
          got.active_priority !== want.active_priority) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch at %0t: expected period=%0d compare=%0d active=%b power=%b",
                   $realtime, want.pwm_period, want.pwm_compare, want.pwm_active,
                   want.power_on);
          $display("  expected playing=%b prio=%0d", want.playing, want.active_priority);
          $display("  got period=%0d compare=%0d active=%b power=%b playing=%b prio=%0d",
                   got.pwm_period, got.pwm_compare, got.pwm_active, got.power_on,
                   got.playing, got.active_priority);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [6:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;

  melody_tracker trk;
  bit            calm = 1'b0;
  bit            hold_req = 1'b0;
  int            hold_left = 0;
  int            sent = 0;
  int            idle_cycles = 0;

  buzzer_melody_sequencer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // never let a request act on a note from a slot that was never written
  function automatic req_t make_safe(req_t r);
    logic [15:0] nxt;
    if (r.op == bms_pkg::OP_START && int'(r.tune) >= trk.prio &&
        !trk.written[int'(r.tune) * bms_pkg::NOTES_PER_TUNE]) begin
      r.op   = bms_pkg::OP_WRITE;
      r.slot = '0;
    end else if (r.op == bms_pkg::OP_TICK && trk.busy) begin
      nxt = (trk.elapsed == 16'hFFFF) ? trk.elapsed : trk.elapsed + 16'd1;
      if (nxt >= trk.cur.duration && trk.pos + 1 < bms_pkg::NOTES_PER_TUNE &&
          !trk.written[trk.tune_now * bms_pkg::NOTES_PER_TUNE + trk.pos + 1]) begin
        r.op   = bms_pkg::OP_WRITE;
        r.tune = trk.tune_now[2:0];
        r.slot = 5'(trk.pos + 1);
      end
    end
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.op       = 2'($urandom_range(0, 3));
    r.tune     = 3'($urandom_range(0, 7));
    r.slot     = 5'($urandom_range(0, 31));
    r.period   = 16'($urandom_range(0, 65535));
    r.duration = 16'($urandom_range(0, 65535));
    r.is_end   = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic logic [15:0] short_duration();
    if ($urandom_range(0, 99) < 5) return 16'($urandom_range(4, 20));
    return 16'($urandom_range(0, 3));
  endfunction

  task automatic send_req(input req_t r);
    r = make_safe(r);
    while (!calm && $urandom_range(0, 99) < 35) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {r.duration, r.period, r.slot, r.tune};
    s_axis_tuser_i  <= r.op;
    s_axis_tlast_i  <= r.is_end;
    do @(posedge clk_i); while (!s_axis_tready_o);
    trk.apply_request(r);
    sent++;
  endtask

  task automatic send_fields(input logic [1:0] op, input int tune, input int slot,
                             input int period, input int duration, input bit is_end);
    req_t r;
    r = '{op, tune[2:0], slot[4:0], period[15:0], duration[15:0], is_end};
    send_req(r);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (trk.timer_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_duty(input int d);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= d[6:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    trk.duty = d;
  endtask

  task automatic run_scenario();
    req_t r;
    int   pick;
    int   t;
    int   len;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      // program a tune, start it and let it play for a while
      t   = ($urandom_range(0, 9) < 7) ? $urandom_range(trk.prio, 7) : $urandom_range(0, 7);
      len = ($urandom_range(0, 99) < 12) ? bms_pkg::NOTES_PER_TUNE : $urandom_range(1, 6);
      for (int s = 0; s < len; s++) begin
        r          = rand_req();
        r.op       = bms_pkg::OP_WRITE;
        r.tune     = t[2:0];
        r.slot     = s[4:0];
        r.period   = ($urandom_range(0, 99) < 20) ? 16'd0 : 16'($urandom_range(1, 65535));
        r.duration = short_duration();
        r.is_end   = (s == len - 1 && len < bms_pkg::NOTES_PER_TUNE) ||
                     (s > 0 && $urandom_range(0, 99) < 5);
        send_req(r);
      end
      r      = rand_req();
      r.op   = bms_pkg::OP_START;
      r.tune = t[2:0];
      send_req(r);
      repeat ($urandom_range(0, len * 3)) begin
        r    = rand_req();
        r.op = bms_pkg::OP_TICK;
        send_req(r);
      end
    end else if (pick < 70) begin
      repeat ($urandom_range(1, 10)) begin
        r    = rand_req();
        r.op = bms_pkg::OP_TICK;
        send_req(r);
      end
    end else if (pick < 85) begin
      r    = rand_req();
      r.op = bms_pkg::OP_START;
      send_req(r);
    end else if (pick < 95) begin
      r    = rand_req();
      r.op = bms_pkg::OP_WRITE;
      if ($urandom_range(0, 1)) r.duration = short_duration();
      send_req(r);
    end else begin
      r    = rand_req();
      r.op = OP_UNUSED;
      send_req(r);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        trk.compare_timer(bms_pkg::result_t'(m_axis_tdata_o));
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= calm || ($urandom_range(0, 99) >= 35);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int duty_plan [6];
    int target;
    trk = new();
    duty_plan = '{0, 127, 100, 1, 0, 73};
    duty_plan[4] = $urandom_range(0, 127);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // tick while idle, unused op, end flag on the first slot
    send_fields(bms_pkg::OP_TICK,  0, 0, 0, 0, 1'b0);
    send_fields(OP_UNUSED,         0, 0, 0, 0, 1'b0);
    send_fields(bms_pkg::OP_WRITE, 0, 0, 0, 0, 1'b1);
    send_fields(bms_pkg::OP_START, 0, 0, 0, 0, 1'b0);
    // top tune with max period, a rest, and an end note
    send_fields(bms_pkg::OP_WRITE, 7, 0, 65535, 1, 1'b0);
    send_fields(bms_pkg::OP_WRITE, 7, 1, 0, 0, 1'b0);
    send_fields(bms_pkg::OP_WRITE, 7, 2, 1, 3, 1'b0);
    send_fields(bms_pkg::OP_WRITE, 7, 3, 1000, 0, 1'b1);
    send_fields(bms_pkg::OP_WRITE, 3, 0, 0, 2, 1'b0);
    send_fields(bms_pkg::OP_WRITE, 3, 1, 300, 0, 1'b1);
    send_fields(bms_pkg::OP_WRITE, 5, 31, 65535, 65535, 1'b1);
    send_fields(bms_pkg::OP_START, 7, 0, 0, 0, 1'b0);
    // lower priority start is refused
    send_fields(bms_pkg::OP_START, 3, 0, 0, 0, 1'b0);
    send_fields(bms_pkg::OP_TICK,  0, 0, 0, 0, 1'b0);
    send_fields(bms_pkg::OP_TICK,  0, 0, 0, 0, 1'b0);
    // restart at equal priority
    send_fields(bms_pkg::OP_START, 7, 0, 0, 0, 1'b0);
    repeat (5) send_fields(bms_pkg::OP_TICK, 0, 0, 0, 0, 1'b0);
    // rest on the first slot
    send_fields(bms_pkg::OP_START, 3, 0, 0, 0, 1'b0);
    repeat (2) send_fields(bms_pkg::OP_TICK, 0, 0, 0, 0, 1'b0);

    foreach (duty_plan[k]) begin
      drain();
      set_duty(duty_plan[k]);
      calm = (k == 1);
      if (k == 0) hold_req = 1'b1;
      target = sent + CHUNK;
      while (sent < target) run_scenario();
    end
    calm = 1'b0;
    drain();
    repeat (10) @(posedge clk_i);

    if (trk.errors == 0 && trk.timer_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
